@@ rtl/rekq_pkg.sv @@
// shared types and constants for the rotary knob qualifier
`default_nettype none

package rekq_pkg;

    // default number of knobs and register reset values
    localparam int NUM_KNOBS_DEFAULT = 2;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [7:0] DETENT_RESET = 8'd4;

    // configuration port geometry
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_MS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNTS_PER_DETENT = 2'd1;

    // item operation codes
    typedef enum logic [1:0] {
        OP_LATCH    = 2'd0,
        OP_UPDATE   = 2'd1,
        OP_READ_DIR = 2'd2,
        OP_READ_BTN = 2'd3
    } op_t;

    // direction result codes
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } dir_t;

    // input beat
    typedef struct packed {
        op_t         operation;
        logic        encoder_id;
        logic [15:0] counter_value;
        logic        button_level;
        logic [31:0] now_ms;
    } item_t;

    // result beat
    typedef struct packed {
        dir_t direction;
        logic button_pressed;
    } result_t;

    // configuration registers as seen by each knob
    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [7:0]  counts_per_detent;
    } cfg_t;

endpackage

`default_nettype wire

@@ rtl/rotary_encoder_knob_qualifier.sv @@
// top level: input register, knob bank, result register and config registers
//
//  channel  direction  handshake              payload
//  item     in         item_valid/item_stall  item (operation, knob, counter, button, time)
//  result   out        result_valid/result_stall  result (direction, button_pressed)
//  config   in         cfg_write              cfg_index, cfg_data
//
// one beat is accepted per cycle while item_stall is low; it passes through the input
// register, then the result register, before its result is valid
// knob state is read, updated and written back between the two registers, at the edge
// that loads the result register, so consecutive beats on a knob see each other's effect
// item_stall rises only while a beat waits and the result register is held
// reset puts every knob at baseline 0, accumulator 0, button released, no press
`default_nettype none

module rotary_encoder_knob_qualifier #(
    parameter int NUM_KNOBS = rekq_pkg::NUM_KNOBS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_stall,
    input  wire rekq_pkg::item_t                   item,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output rekq_pkg::result_t                      result,
    input  wire logic                              cfg_write,
    input  wire logic [rekq_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [rekq_pkg::CFG_DATA_W-1:0]   cfg_data
);

    rekq_pkg::item_t   item_reg;
    logic              item_valid_reg;
    logic              item_valid_next;
    rekq_pkg::result_t result_reg;
    rekq_pkg::result_t result_next;
    logic              result_valid_reg;
    logic              result_valid_next;
    rekq_pkg::cfg_t    cfg_reg;
    rekq_pkg::cfg_t    cfg_next;
    logic              advance;
    logic [NUM_KNOBS-1:0] knob_sel;
    rekq_pkg::result_t knob_result [NUM_KNOBS];

    // a held beat moves on when the result register is empty or being taken
    assign advance = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !advance;
    assign result_valid = result_valid_reg;
    assign result = result_reg;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            if (cfg_index == rekq_pkg::CFG_DEBOUNCE_MS)
            begin
                cfg_next.debounce_ms = cfg_data;
            end
            else if (cfg_index == rekq_pkg::CFG_COUNTS_PER_DETENT)
            begin
                cfg_next.counts_per_detent = cfg_data[7:0];
            end
        end
    end

    // knob bank, one instance per knob
    genvar k;
    generate
        for (k = 0; k < NUM_KNOBS; k++)
        begin : g_knob
            assign knob_sel[k] = advance && (int'(item_reg.encoder_id) == k);
            rekq_knob u_knob (
                .clk    (clk),
                .rst_n  (rst_n),
                .sel    (knob_sel[k]),
                .item   (item_reg),
                .cfg    (cfg_reg),
                .result (knob_result[k])
            );
        end
    endgenerate

    // merge knob results, unselected knobs answer zero
    always_comb
    begin
        logic [2:0] merged;
        merged = 3'd0;
        for (int i = 0; i < NUM_KNOBS; i++)
        begin
            merged = merged | knob_result[i];
        end
        result_next = result_reg;
        if (advance)
        begin
            result_next = rekq_pkg::result_t'(merged);
        end
    end

    // handshake next state
    always_comb
    begin
        item_valid_next = item_stall ? item_valid_reg : item_valid;
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else
        begin
            result_valid_next = result_valid_reg && result_stall;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
            cfg_reg <= '{debounce_ms: rekq_pkg::DEBOUNCE_RESET,
                         counts_per_detent: rekq_pkg::DETENT_RESET};
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            result_valid_reg <= result_valid_next;
            cfg_reg <= cfg_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!item_stall)
        begin
            item_reg <= item;
        end
        result_reg <= result_next;
    end

    // at most one knob takes a beat
    a_one_knob: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(knob_sel))
        else $error("more than one knob selected");

    // a result never carries both a direction and a press
    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.direction == rekq_pkg::DIR_NONE
                              || !result_reg.button_pressed))
        else $error("result carries direction and press together");

    // input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (item_valid_reg && result_valid_reg && result_stall))
        else $error("input stalled without a held result");

    // a processed beat always lands in the result register
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("processed beat lost");

endmodule

`default_nettype wire

@@ rtl/rekq_knob.sv @@
// one knob: counter baseline, step accumulator, button debounce and press flag
`default_nettype none

module rekq_knob (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           sel,
    input  wire rekq_pkg::item_t item,
    input  wire rekq_pkg::cfg_t  cfg,
    output rekq_pkg::result_t    result
);

    logic [15:0] last_count_reg;
    logic [15:0] last_count_next;
    logic [15:0] step_accum_reg;
    logic [15:0] step_accum_next;
    logic        stable_level_reg;
    logic        stable_level_next;
    logic        press_pending_reg;
    logic        press_pending_next;
    logic [31:0] last_change_ms_reg;
    logic [31:0] last_change_ms_next;

    logic [15:0]        diff;
    logic signed [16:0] acc_sum;
    logic [15:0]        acc_sat;
    logic [7:0]         detent;
    logic signed [16:0] acc_ext;
    logic signed [16:0] det_ext;
    logic signed [16:0] acc_plus_det;
    logic signed [16:0] acc_minus_det;
    logic               dir_cw;
    logic               dir_ccw;
    logic [31:0]        elapsed;
    logic               level_ok;

    // counter difference and saturating accumulate
    always_comb
    begin
        diff = item.counter_value - last_count_reg;
        acc_sum = $signed({step_accum_reg[15], step_accum_reg})
                + $signed({diff[15], diff});
        if (acc_sum[16] != acc_sum[15])
        begin
            acc_sat = acc_sum[16] ? 16'h8000 : 16'h7fff;
        end
        else
        begin
            acc_sat = acc_sum[15:0];
        end
    end

    // detent compare, zero detent size acts as one
    always_comb
    begin
        detent = (cfg.counts_per_detent == 8'd0) ? 8'd1 : cfg.counts_per_detent;
        acc_ext = $signed({step_accum_reg[15], step_accum_reg});
        det_ext = $signed({9'd0, detent});
        acc_plus_det = acc_ext + det_ext;
        acc_minus_det = acc_ext - det_ext;
        dir_cw = (acc_ext >= det_ext);
        dir_ccw = (acc_plus_det <= 17'sd0);
    end

    // wrap-safe debounce window
    always_comb
    begin
        elapsed = item.now_ms - last_change_ms_reg;
        level_ok = (item.button_level != stable_level_reg)
                && (elapsed > {16'd0, cfg.debounce_ms});
    end

    // state update and result for a selected beat
    always_comb
    begin
        last_count_next = last_count_reg;
        step_accum_next = step_accum_reg;
        stable_level_next = stable_level_reg;
        press_pending_next = press_pending_reg;
        last_change_ms_next = last_change_ms_reg;
        result = '{direction: rekq_pkg::DIR_NONE, button_pressed: 1'b0};
        if (sel)
        begin
            unique case (item.operation)
                rekq_pkg::OP_LATCH:
                begin
                    last_count_next = item.counter_value;
                end
                rekq_pkg::OP_UPDATE:
                begin
                    if (diff != 16'd0)
                    begin
                        step_accum_next = acc_sat;
                        last_count_next = item.counter_value;
                    end
                    if (level_ok)
                    begin
                        stable_level_next = item.button_level;
                        last_change_ms_next = item.now_ms;
                        if (!item.button_level)
                        begin
                            press_pending_next = 1'b1;
                        end
                    end
                end
                rekq_pkg::OP_READ_DIR:
                begin
                    priority if (dir_cw)
                    begin
                        step_accum_next = acc_minus_det[15:0];
                        result.direction = rekq_pkg::DIR_CW;
                    end
                    else if (dir_ccw)
                    begin
                        step_accum_next = acc_plus_det[15:0];
                        result.direction = rekq_pkg::DIR_CCW;
                    end
                    else
                    begin
                        step_accum_next = step_accum_reg;
                    end
                end
                rekq_pkg::OP_READ_BTN:
                begin
                    press_pending_next = 1'b0;
                    result.button_pressed = press_pending_reg;
                end
                default:
                begin
                    last_count_next = last_count_reg;
                end
            endcase
        end
    end

    // knob state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg <= 16'd0;
            step_accum_reg <= 16'd0;
            stable_level_reg <= 1'b1;
            press_pending_reg <= 1'b0;
            last_change_ms_reg <= 32'd0;
        end
        else
        begin
            last_count_reg <= last_count_next;
            step_accum_reg <= step_accum_next;
            stable_level_reg <= stable_level_next;
            press_pending_reg <= press_pending_next;
            last_change_ms_reg <= last_change_ms_next;
        end
    end

endmodule

`default_nettype wire

@@ test/rotary_encoder_knob_qualifier_test.sv @@
// self-checking testbench for the rotary knob qualifier: directed and random beats
`default_nettype none

module rotary_encoder_knob_qualifier_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int KNOBS = rekq_pkg::NUM_KNOBS_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PHASES = 6;
    localparam int BEATS_PER_PHASE = 64;

    // register indexes with no register behind them
    localparam logic [rekq_pkg::CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [rekq_pkg::CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    // input beat waiting to be driven, optionally held until the block drains
    typedef struct {
        rekq_pkg::item_t beat;
        bit              drain_first;
    } queued_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic item_valid = 1'b0;
    logic item_stall;
    rekq_pkg::item_t item_beat = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    rekq_pkg::result_t result_beat;
    logic cfg_write = 1'b0;
    logic [rekq_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [rekq_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // beats still to send and answers still to arrive
    queued_beat_t beat_backlog[$];
    rekq_pkg::result_t knob_answers[$];

    // idle rates in percent for sender and receiver
    int sender_pct = 37;
    int receiver_pct = 48;

    int mismatches = 0;
    int cycle_count = 0;

    // predicted registers and knob state
    logic [15:0] model_debounce;
    logic [7:0]  model_detent;
    logic [15:0] model_base[KNOBS];
    int          model_accum[KNOBS];
    logic        model_level[KNOBS];
    logic        model_press[KNOBS];
    logic [31:0] model_stamp[KNOBS];

    // stimulus-side view of each knob, used to build plausible sequences
    logic [15:0] gen_count[KNOBS];
    logic        gen_level[KNOBS];
    logic [31:0] gen_clock;

    rotary_encoder_knob_qualifier dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_beat),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // knob state after reset
    initial
    begin : model_reset
        int k;
        model_debounce = rekq_pkg::DEBOUNCE_RESET;
        model_detent = rekq_pkg::DETENT_RESET;
        gen_clock = '0;
        for (k = 0; k < KNOBS; k++)
        begin
            model_base[k] = '0;
            model_accum[k] = 0;
            model_level[k] = 1'b1;
            model_press[k] = 1'b0;
            model_stamp[k] = '0;
            gen_count[k] = '0;
            gen_level[k] = 1'b1;
        end
    end

    // predicted answer for one accepted beat, advancing the knob state
    function automatic rekq_pkg::result_t qualify_beat(rekq_pkg::item_t b);
        rekq_pkg::result_t r;
        int k;
        int diff;
        int sum;
        int step;
        logic [15:0] delta;
        logic [31:0] elapsed;
        r.direction = rekq_pkg::DIR_NONE;
        r.button_pressed = 1'b0;
        k = int'(b.encoder_id);
        if (k < KNOBS)
        begin
            case (b.operation)
                rekq_pkg::OP_LATCH:
                begin
                    model_base[k] = b.counter_value;
                end
                rekq_pkg::OP_UPDATE:
                begin
                    // wrapped signed counter difference, saturating accumulate
                    delta = b.counter_value - model_base[k];
                    diff = int'($signed(delta));
                    if (diff != 0)
                    begin
                        sum = model_accum[k] + diff;
                        if (sum > 32767)
                            sum = 32767;
                        if (sum < -32768)
                            sum = -32768;
                        model_accum[k] = sum;
                        model_base[k] = b.counter_value;
                    end
                    // debounce with wrap-safe elapsed time
                    elapsed = b.now_ms - model_stamp[k];
                    if (b.button_level != model_level[k] && elapsed > {16'd0, model_debounce})
                    begin
                        model_level[k] = b.button_level;
                        model_stamp[k] = b.now_ms;
                        if (b.button_level == 1'b0)
                            model_press[k] = 1'b1;
                    end
                end
                rekq_pkg::OP_READ_DIR:
                begin
                    step = (model_detent == 8'd0) ? 1 : int'(model_detent);
                    if (model_accum[k] >= step)
                    begin
                        model_accum[k] -= step;
                        r.direction = rekq_pkg::DIR_CW;
                    end
                    else if (model_accum[k] <= -step)
                    begin
                        model_accum[k] += step;
                        r.direction = rekq_pkg::DIR_CCW;
                    end
                end
                default:
                begin
                    if (model_press[k])
                    begin
                        model_press[k] = 1'b0;
                        r.button_pressed = 1'b1;
                    end
                end
            endcase
        end
        return r;
    endfunction

    // input driver: hold a stalled beat, else maybe idle, else send the next one once any drain it asks for is done
    always @(posedge clk)
    begin : item_driver
        bit take;
        bit gap;
        queued_beat_t head;
        take = item_valid && !item_stall;
        if (take)
            knob_answers.push_back(qualify_beat(item_beat));
        if (rst_n && !(item_valid && !take))
        begin
            gap = $urandom_range(0, 99) < sender_pct;
            if (beat_backlog.size() != 0 && !gap &&
                !(beat_backlog[0].drain_first && knob_answers.size() != 0))
            begin
                head = beat_backlog.pop_front();
                item_beat <= head.beat;
                item_valid <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // result monitor: compare each taken result with the oldest answer
    always @(posedge clk)
    begin : result_monitor
        rekq_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (knob_answers.size() == 0)
            begin
                $display("%0t: unexpected result direction %0d button %0b", $time,
                         result_beat.direction, result_beat.button_pressed);
                mismatches++;
            end
            else
            begin
                want = knob_answers.pop_front();
                if (result_beat.direction !== want.direction)
                begin
                    $display("%0t: direction expected %0d got %0d", $time,
                             want.direction, result_beat.direction);
                    mismatches++;
                end
                if (result_beat.button_pressed !== want.button_pressed)
                begin
                    $display("%0t: button_pressed expected %0b got %0b", $time,
                             want.button_pressed, result_beat.button_pressed);
                    mismatches++;
                end
            end
        end
        result_stall <= rst_n && ($urandom_range(0, 99) < receiver_pct);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic add_beat(rekq_pkg::op_t op, logic id, logic [15:0] cnt, logic lvl,
                            logic [31:0] now, bit drain_first);
        queued_beat_t q;
        q.beat.operation = op;
        q.beat.encoder_id = id;
        q.beat.counter_value = cnt;
        q.beat.button_level = lvl;
        q.beat.now_ms = now;
        q.drain_first = drain_first;
        beat_backlog.push_back(q);
    endtask

    // register write; caller lowers cfg_write after the last one
    task automatic write_reg(logic [rekq_pkg::CFG_INDEX_W-1:0] idx,
                             logic [rekq_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            rekq_pkg::CFG_DEBOUNCE_MS:       model_debounce = data;
            rekq_pkg::CFG_COUNTS_PER_DETENT: model_detent = data[7:0];
            default:                         ;
        endcase
    endtask

    // wait until every beat is sent and answered, then let the pipeline settle
    task automatic wait_drained();
        do
            @(posedge clk);
        while (beat_backlog.size() != 0 || item_valid || knob_answers.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_phase_regs(int phase);
        case (phase)
            0:
            begin
                // zero detent size and writes to unused indexes
                write_reg(rekq_pkg::CFG_DEBOUNCE_MS, 16'd0);
                write_reg(rekq_pkg::CFG_COUNTS_PER_DETENT, {8'($urandom), 8'd0});
                write_reg(CFG_SPARE_2, 16'($urandom));
                write_reg(CFG_SPARE_3, 16'($urandom));
            end
            1:
            begin
                write_reg(rekq_pkg::CFG_DEBOUNCE_MS, 16'hFFFF);
                write_reg(rekq_pkg::CFG_COUNTS_PER_DETENT, {8'($urandom), 8'd255});
            end
            2:
            begin
                write_reg(rekq_pkg::CFG_DEBOUNCE_MS, 16'($urandom_range(0, 200)));
                write_reg(rekq_pkg::CFG_COUNTS_PER_DETENT, {8'($urandom), 8'd1});
            end
            3:
            begin
                write_reg(rekq_pkg::CFG_DEBOUNCE_MS, 16'($urandom));
                write_reg(rekq_pkg::CFG_COUNTS_PER_DETENT,
                          {8'($urandom), 8'($urandom_range(1, 255))});
            end
            4:
            begin
                write_reg(rekq_pkg::CFG_DEBOUNCE_MS, 16'd10);
                write_reg(rekq_pkg::CFG_COUNTS_PER_DETENT, {8'($urandom), 8'd3});
            end
            default:
            begin
                write_reg(rekq_pkg::CFG_DEBOUNCE_MS, 16'd1000);
                write_reg(rekq_pkg::CFG_COUNTS_PER_DETENT, {8'($urandom), 8'd8});
            end
        endcase
        cfg_write <= 1'b0;
    endtask

    // mostly plausible knob traffic with random content, some pure noise
    task automatic make_random_beats(int count, int drain_at);
        int i;
        int pick;
        logic k;
        rekq_pkg::op_t op;
        logic [15:0] cnt;
        logic [31:0] now;
        logic lvl;
        for (i = 0; i < count; i++)
        begin
            k = 1'($urandom_range(0, KNOBS - 1));
            pick = $urandom_range(0, 99);
            cnt = 16'($urandom);
            now = $urandom;
            lvl = 1'($urandom);
            if (pick < 5)
            begin
                op = rekq_pkg::op_t'($urandom_range(0, 3));
            end
            else if (pick < 15)
            begin
                op = rekq_pkg::OP_LATCH;
                if ($urandom_range(0, 1) == 0)
                    cnt = gen_count[k] + 16'($urandom_range(0, 24)) - 16'd12;
                gen_count[k] = cnt;
            end
            else if (pick < 60)
            begin
                op = rekq_pkg::OP_UPDATE;
                // counter moves a little, sometimes jumps anywhere
                if ($urandom_range(0, 4) != 0)
                    cnt = gen_count[k] + 16'($urandom_range(0, 24)) - 16'd12;
                gen_count[k] = cnt;
                // time moves around the debounce window, sometimes jumps anywhere
                if ($urandom_range(0, 19) == 0)
                    gen_clock = $urandom;
                else
                    gen_clock = gen_clock + $urandom_range(0, 2 * int'(model_debounce) + 4);
                now = gen_clock;
                if ($urandom_range(0, 99) < 35)
                    gen_level[k] = ~gen_level[k];
                lvl = gen_level[k];
            end
            else if (pick < 85)
            begin
                op = rekq_pkg::OP_READ_DIR;
            end
            else
            begin
                op = rekq_pkg::OP_READ_BTN;
            end
            add_beat(op, k, cnt, lvl, now, i == drain_at);
        end
    endtask

    initial
    begin : stimulus
        int phase;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // counting and detent steps at reset settings
        add_beat(rekq_pkg::OP_LATCH,    1'b0, 16'h0000, 1'b1, 32'd0, 1'b0);
        add_beat(rekq_pkg::OP_UPDATE,   1'b0, 16'h0003, 1'b1, 32'd0, 1'b0);
        add_beat(rekq_pkg::OP_READ_DIR, 1'b0, 16'h0000, 1'b1, 32'd0, 1'b0);
        add_beat(rekq_pkg::OP_UPDATE,   1'b0, 16'h0004, 1'b1, 32'd0, 1'b0);
        add_beat(rekq_pkg::OP_READ_DIR, 1'b0, 16'hFFFF, 1'b0, 32'hFFFF_FFFF, 1'b0);
        add_beat(rekq_pkg::OP_READ_DIR, 1'b0, 16'h0000, 1'b1, 32'd0, 1'b0);
        add_beat(rekq_pkg::OP_UPDATE,   1'b0, 16'h0000, 1'b1, 32'd0, 1'b0);
        add_beat(rekq_pkg::OP_READ_DIR, 1'b0, 16'h0000, 1'b1, 32'd0, 1'b0);
        // positive saturation on the second knob
        add_beat(rekq_pkg::OP_LATCH,    1'b1, 16'hFFFF, 1'b1, 32'd0, 1'b0);
        add_beat(rekq_pkg::OP_UPDATE,   1'b1, 16'h7FFE, 1'b1, 32'd0, 1'b0);
        add_beat(rekq_pkg::OP_UPDATE,   1'b1, 16'hFFFD, 1'b1, 32'd0, 1'b0);
        add_beat(rekq_pkg::OP_READ_DIR, 1'b1, 16'h0000, 1'b1, 32'd0, 1'b0);
        // negative saturation
        add_beat(rekq_pkg::OP_LATCH,    1'b0, 16'h0000, 1'b1, 32'd0, 1'b0);
        add_beat(rekq_pkg::OP_UPDATE,   1'b0, 16'h8000, 1'b1, 32'd0, 1'b0);
        add_beat(rekq_pkg::OP_UPDATE,   1'b0, 16'h0000, 1'b1, 32'd0, 1'b0);
        add_beat(rekq_pkg::OP_READ_DIR, 1'b0, 16'h0000, 1'b1, 32'd0, 1'b0);
        // debounce edge: equal to the window is rejected, one more is taken
        add_beat(rekq_pkg::OP_UPDATE,   1'b0, 16'h0000, 1'b0, 32'd50, 1'b0);
        add_beat(rekq_pkg::OP_UPDATE,   1'b0, 16'h0000, 1'b0, 32'd51, 1'b0);
        add_beat(rekq_pkg::OP_READ_BTN, 1'b0, 16'h0000, 1'b1, 32'd0, 1'b1);
        add_beat(rekq_pkg::OP_READ_BTN, 1'b0, 16'h0000, 1'b1, 32'd0, 1'b0);
        // release, then a press across the time wrap
        add_beat(rekq_pkg::OP_UPDATE,   1'b0, 16'h0000, 1'b1, 32'd101, 1'b0);
        add_beat(rekq_pkg::OP_UPDATE,   1'b0, 16'h0000, 1'b1, 32'hFFFF_FFFF, 1'b0);
        add_beat(rekq_pkg::OP_UPDATE,   1'b0, 16'h0000, 1'b0, 32'd31, 1'b0);
        add_beat(rekq_pkg::OP_UPDATE,   1'b0, 16'h0000, 1'b0, 32'd50, 1'b0);
        add_beat(rekq_pkg::OP_READ_BTN, 1'b1, 16'h0000, 1'b1, 32'd0, 1'b0);
        add_beat(rekq_pkg::OP_READ_BTN, 1'b0, 16'h0000, 1'b1, 32'd0, 1'b0);
        wait_drained();

        // random phases under several register settings and idle patterns
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_phase_regs(phase);
            if (phase < 2)
            begin
                sender_pct <= 37;
                receiver_pct <= 48;
            end
            else if (phase < 4)
            begin
                sender_pct <= 48;
                receiver_pct <= 37;
            end
            else
            begin
                sender_pct <= 0;
                receiver_pct <= 0;
            end
            make_random_beats(BEATS_PER_PHASE, $urandom_range(10, BEATS_PER_PHASE - 10));
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0 && knob_answers.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
